// ===== design/tflm_pkg.sv =====
package tflm_pkg;

   localparam int FIELD_W = 24;
   localparam int POS_W   = 32;
   localparam int WGT_W   = 16;
   localparam int FRAC_W  = 44;

   // one grid node, all three components
   typedef struct packed {
      logic signed [FIELD_W-1:0] bx;
      logic signed [FIELD_W-1:0] by;
      logic signed [FIELD_W-1:0] bz;
   } node_type;

   // load enables of the three address-mapping stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

// ===== design/tflm_bank.sv =====
module tflm_bank #(
   parameter int AW = 12
) (
   input  logic               clock,
   input  logic               en,
   input  logic               we,
   input  logic [AW-1:0]      addr,
   input  tflm_pkg::node_type wdata,
   output tflm_pkg::node_type rdata
);
   import tflm_pkg::*;

   node_type mem [2**AW];
   node_type rdata_ff;

   // single port: one write or one registered read per cycle while en is high
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tflm_axis.sv =====
module tflm_axis #(
   parameter int N = 32
) (
   input  logic                     clock,
   input  tflm_pkg::stage_en_type   en,
   input  logic signed [31:0]       pos,
   input  logic signed [31:0]       origin,
   input  logic signed [31:0]       scale,
   output logic [$clog2(N)-1:0]     idx,
   output logic [15:0]              wgt,
   output logic                     in_grid
);
   import tflm_pkg::*;

   localparam int IW = $clog2(N);

   logic signed [32:0] d_ff;
   logic signed [49:0] plo_ff;
   logic signed [48:0] phi_ff;
   logic signed [64:0] u;
   logic [IW-1:0]      idx_ff;
   logic [WGT_W-1:0]   wgt_ff;
   logic               in_grid_ff;

   // stage 1: offset from origin, exact
   always_ff @(posedge clock) begin
      if (en.s1) begin
         d_ff <= {pos[31], pos} - {origin[31], origin};
      end
   end

   // stage 2: 33x32 product split into a 33x17 (zero-extended low half) and a 33x16 partial product
   always_ff @(posedge clock) begin
      if (en.s2) begin
         plo_ff <= d_ff * $signed({1'b0, scale[15:0]});
         phi_ff <= d_ff * $signed(scale[31:16]);
      end
   end

   // stage 3: combine, range check, cell index and weight
   assign u = ($signed({{16{phi_ff[48]}}, phi_ff}) <<< 16)
            + $signed({{15{plo_ff[49]}}, plo_ff});

   always_ff @(posedge clock) begin
      if (en.s3) begin
         in_grid_ff <= !u[64] && (u[63:FRAC_W] < 20'(N - 1));
         idx_ff     <= u[FRAC_W+IW-1:FRAC_W];
         wgt_ff     <= u[FRAC_W-1:FRAC_W-WGT_W];
      end
   end

   assign idx     = idx_ff;
   assign wgt     = wgt_ff;
   assign in_grid = in_grid_ff;

endmodule

// ===== design/trilinear_field_map_lookup.sv =====
// Trilinear field-map lookup. Nodes are loaded in file order (z fastest, then y,
// then x) with cmd 0; a query (cmd 1) maps the point onto the grid per axis as
// (pos - origin) * scale and returns the trilinear blend of the eight surrounding
// nodes, or zeros with inside_res clear when the point is off the grid. The block
// takes one request per cycle unless rsp_stall backs up the pipeline; loads produce
// no result. The eight corners come from eight parity banks (one per x/y/z
// parity), each doing one read or write per unstalled cycle, so loads and queries
// interleave freely. Node stores are not cleared at reset.
module trilinear_field_map_lookup #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [23:0] req_node_bx,
   input  logic signed [23:0] req_node_by,
   input  logic signed [23:0] req_node_bz,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_b_x,
   output logic signed [23:0] rsp_b_y,
   output logic signed [23:0] rsp_b_z,
   output logic               rsp_inside_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import tflm_pkg::*;

   localparam int XW = $clog2(GRID_X);
   localparam int YW = $clog2(GRID_Y);
   localparam int ZW = $clog2(GRID_Z);
   localparam int HX = (XW > 1) ? XW - 1 : 1;
   localparam int HY = (YW > 1) ? YW - 1 : 1;
   localparam int HZ = (ZW > 1) ? ZW - 1 : 1;
   localparam int AW = HX + HY + HZ;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_SCALE_X  = 3'd3,
      REG_SCALE_Y  = 3'd4,
      REG_SCALE_Z  = 3'd5
   } reg_idx_type;

   typedef struct packed {
      node_type      node;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [ZW-1:0] z;
   } load_type;

   // blend a toward b by w/65536, rounded half up
   function automatic logic signed [23:0] blend(input logic signed [23:0] a,
                                                input logic signed [23:0] b,
                                                input logic [15:0] w);
      logic signed [24:0] diff;
      logic signed [41:0] prod;
      logic signed [41:0] v;
      diff = {b[23], b} - {a[23], a};
      prod = diff * $signed({1'b0, w});
      v    = $signed({{2{a[23]}}, a, 16'd0}) + prod + 42'sd32768;
      return v[39:16];
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [31:0] scale_x_ff, scale_y_ff, scale_z_ff;
   reg_idx_type        reg_idx;

   assign reg_idx = reg_idx_type'(paddr[4:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         scale_x_ff  <= 32'sh1000_0000;
         scale_y_ff  <= 32'sh1000_0000;
         scale_z_ff  <= 32'sh1000_0000;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            REG_ORIGIN_X: origin_x_ff <= pwdata;
            REG_ORIGIN_Y: origin_y_ff <= pwdata;
            REG_ORIGIN_Z: origin_z_ff <= pwdata;
            REG_SCALE_X:  scale_x_ff  <= pwdata;
            REG_SCALE_Y:  scale_y_ff  <= pwdata;
            REG_SCALE_Z:  scale_z_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ORIGIN_X: prdata = origin_x_ff;
         REG_ORIGIN_Y: prdata = origin_y_ff;
         REG_ORIGIN_Z: prdata = origin_z_ff;
         REG_SCALE_X:  prdata = scale_x_ff;
         REG_SCALE_Y:  prdata = scale_y_ff;
         REG_SCALE_Z:  prdata = scale_z_ff;
         default:      prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic [7:1] v_ff;
   logic [7:1] en;
   logic [4:1] q_ff;

   always_comb begin
      en[7] = !v_ff[7] || !rsp_stall;
      for (int k = 6; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= req_valid;
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
         if (en[4]) v_ff[4] <= v_ff[3];
         if (en[5]) v_ff[5] <= v_ff[4] && q_ff[4];
         if (en[6]) v_ff[6] <= v_ff[5];
         if (en[7]) v_ff[7] <= v_ff[6];
      end
   end

   // ---------------- load address counters ----------------
   logic [XW-1:0] lx_ff, lx_in;
   logic [YW-1:0] ly_ff, ly_in;
   logic [ZW-1:0] lz_ff, lz_in;
   logic          load_acc;

   assign load_acc = req_valid && en[1] && !req_cmd;

   always_comb begin
      lx_in = lx_ff;
      ly_in = ly_ff;
      lz_in = lz_ff + 1'b1;
      if (lz_ff == ZW'(GRID_Z - 1)) begin
         lz_in = '0;
         ly_in = ly_ff + 1'b1;
         if (ly_ff == YW'(GRID_Y - 1)) begin
            ly_in = '0;
            lx_in = (lx_ff == XW'(GRID_X - 1)) ? '0 : lx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff <= '0;
         ly_ff <= '0;
         lz_ff <= '0;
      end else if (load_acc) begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         lz_ff <= lz_in;
      end
   end

   // ---------------- stages 1-3: load payload, command through stage 4 ----------------
   load_type ld_ff [1:3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q_ff[1]  <= req_cmd;
         ld_ff[1] <= '{node: '{bx: req_node_bx, by: req_node_by, bz: req_node_bz},
                       x: lx_ff, y: ly_ff, z: lz_ff};
      end
      if (en[2]) begin
         q_ff[2]  <= q_ff[1];
         ld_ff[2] <= ld_ff[1];
      end
      if (en[3]) begin
         q_ff[3]  <= q_ff[2];
         ld_ff[3] <= ld_ff[2];
      end
      if (en[4]) begin
         q_ff[4]  <= q_ff[3];
      end
   end

   // ---------------- stages 1-3: per-axis mapping ----------------
   stage_en_type  axis_en;
   logic [XW-1:0] ix;
   logic [YW-1:0] iy;
   logic [ZW-1:0] iz;
   logic [15:0]   wx3, wy3, wz3;
   logic          in_x, in_y, in_z;

   assign axis_en = '{s1: en[1], s2: en[2], s3: en[3]};

   tflm_axis #(.N(GRID_X)) u_axis_x (
      .clock(clock), .en(axis_en), .pos(req_pos_x), .origin(origin_x_ff),
      .scale(scale_x_ff), .idx(ix), .wgt(wx3), .in_grid(in_x)
   );
   tflm_axis #(.N(GRID_Y)) u_axis_y (
      .clock(clock), .en(axis_en), .pos(req_pos_y), .origin(origin_y_ff),
      .scale(scale_y_ff), .idx(iy), .wgt(wy3), .in_grid(in_y)
   );
   tflm_axis #(.N(GRID_Z)) u_axis_z (
      .clock(clock), .en(axis_en), .pos(req_pos_z), .origin(origin_z_ff),
      .scale(scale_z_ff), .idx(iz), .wgt(wz3), .in_grid(in_z)
   );

   // ---------------- stage 4: parity-banked node memory ----------------
   node_type rd [8];
   logic [15:0] wx4_ff, wy4_ff, wz4_ff;
   logic        in4_ff;
   logic [2:0]  par4_ff;

   for (genvar k = 0; k < 8; k++) begin : g_bank
      localparam logic PX = k[2];
      localparam logic PY = k[1];
      localparam logic PZ = k[0];
      logic [XW-1:0] cx;
      logic [YW-1:0] cy;
      logic [ZW-1:0] cz;
      logic [AW-1:0] addr;
      logic          we;

      always_comb begin
         if (q_ff[3]) begin
            cx = ix + XW'(ix[0] ^ PX);
            cy = iy + YW'(iy[0] ^ PY);
            cz = iz + ZW'(iz[0] ^ PZ);
         end else begin
            cx = ld_ff[3].x;
            cy = ld_ff[3].y;
            cz = ld_ff[3].z;
         end
         addr = {HX'(cx >> 1), HY'(cy >> 1), HZ'(cz >> 1)};
         we   = v_ff[3] && !q_ff[3] && ({ld_ff[3].x[0], ld_ff[3].y[0], ld_ff[3].z[0]}
                                        == 3'(k));
      end

      tflm_bank #(.AW(AW)) u_bank (
         .clock(clock), .en(en[4]), .we(we), .addr(addr),
         .wdata(ld_ff[3].node), .rdata(rd[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         wx4_ff  <= wx3;
         wy4_ff  <= wy3;
         wz4_ff  <= wz3;
         in4_ff  <= in_x && in_y && in_z;
         par4_ff <= {ix[0], iy[0], iz[0]};
      end
   end

   // ---------------- stage 5: blend along z ----------------
   logic signed [23:0] c5_ff [3][2][2];
   logic [15:0]        wx5_ff, wy5_ff;
   logic               in5_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
               c5_ff[0][a][b] <= blend(
                  rd[{par4_ff[2] ^ a[0], par4_ff[1] ^ b[0], par4_ff[0]}].bx,
                  rd[{par4_ff[2] ^ a[0], par4_ff[1] ^ b[0], !par4_ff[0]}].bx, wz4_ff);
               c5_ff[1][a][b] <= blend(
                  rd[{par4_ff[2] ^ a[0], par4_ff[1] ^ b[0], par4_ff[0]}].by,
                  rd[{par4_ff[2] ^ a[0], par4_ff[1] ^ b[0], !par4_ff[0]}].by, wz4_ff);
               c5_ff[2][a][b] <= blend(
                  rd[{par4_ff[2] ^ a[0], par4_ff[1] ^ b[0], par4_ff[0]}].bz,
                  rd[{par4_ff[2] ^ a[0], par4_ff[1] ^ b[0], !par4_ff[0]}].bz, wz4_ff);
            end
         end
         wx5_ff <= wx4_ff;
         wy5_ff <= wy4_ff;
         in5_ff <= in4_ff;
      end
   end

   // ---------------- stage 6: blend along y ----------------
   logic signed [23:0] c6_ff [3][2];
   logic [15:0]        wx6_ff;
   logic               in6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int c = 0; c < 3; c++) begin
            for (int a = 0; a < 2; a++) begin
               c6_ff[c][a] <= blend(c5_ff[c][a][0], c5_ff[c][a][1], wy5_ff);
            end
         end
         wx6_ff <= wx5_ff;
         in6_ff <= in5_ff;
      end
   end

   // ---------------- stage 7: blend along x, output register ----------------
   logic signed [23:0] b7_ff [3];
   logic               in7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int c = 0; c < 3; c++) begin
            b7_ff[c] <= in6_ff ? blend(c6_ff[c][0], c6_ff[c][1], wx6_ff) : 24'sd0;
         end
         in7_ff <= in6_ff;
      end
   end

   assign rsp_valid      = v_ff[7];
   assign rsp_b_x        = b7_ff[0];
   assign rsp_b_y        = b7_ff[1];
   assign rsp_b_z        = b7_ff[2];
   assign rsp_inside_res = in7_ff;

endmodule

// ===== verif/tb_trilinear_field_map_lookup.sv =====
module tb_trilinear_field_map_lookup;
   import tflm_pkg::*;

   localparam int GX = 32;
   localparam int GY = 32;
   localparam int GZ = 64;
   localparam int NODES = GX * GY * GZ;
   // nodes loaded up front: covers every corner of cells with x and y index 0
   localparam int LOADED = (GY + 2) * GZ;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 12;

   // register byte addresses
   localparam logic [4:0] REG_ORIGIN_X = 5'd0;
   localparam logic [4:0] REG_ORIGIN_Y = 5'd4;
   localparam logic [4:0] REG_ORIGIN_Z = 5'd8;
   localparam logic [4:0] REG_SCALE_X  = 5'd12;
   localparam logic [4:0] REG_SCALE_Y  = 5'd16;
   localparam logic [4:0] REG_SCALE_Z  = 5'd20;

   localparam bit CMD_LOAD  = 1'b0;
   localparam bit CMD_QUERY = 1'b1;

   localparam int SCALE_ONE = 32'h1000_0000;

   typedef struct packed {
      logic signed [FIELD_W-1:0] bx;
      logic signed [FIELD_W-1:0] by;
      logic signed [FIELD_W-1:0] bz;
      logic                      inside_res;
   } field_result_type;

   // expected-field tracker: mirrors the node stores and the mapping registers
   class field_map_scoreboard;
      int               node_x[NODES];
      int               node_y[NODES];
      int               node_z[NODES];
      int unsigned      load_ptr;
      int               origin[3];
      int               scale[3];
      field_result_type expected_fields[$];
      int               mismatches;

      function new();
         load_ptr = 0;
         origin = '{0, 0, 0};
         scale = '{SCALE_ONE, SCALE_ONE, SCALE_ONE};
         mismatches = 0;
      endfunction

      function bit map_axis(int pos, int org, int scl, int n, output int idx,
                            output longint w);
         longint u;
         u = (longint'(pos) - longint'(org)) * longint'(scl);
         idx = 0;
         w = 0;
         if (u < 0 || u >= (longint'(n - 1) <<< FRAC_W)) return 0;
         idx = int'(u >>> FRAC_W);
         w = (u >>> 28) & 64'hFFFF;
         return 1;
      endfunction

      function longint mix(longint a, longint b, longint w);
         return (a * (65536 - w) + b * w + 32768) >>> 16;
      endfunction

      function longint node_val(int comp, int idx);
         case (comp)
            0: return node_x[idx];
            1: return node_y[idx];
            default: return node_z[idx];
         endcase
      endfunction

      function logic signed [FIELD_W-1:0] interp(int comp, int ix, int iy, int iz,
                                                 longint wx, longint wy, longint wz);
         longint c[2][2];
         longint v;
         int b0;
         for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++) begin
               b0 = ((ix + a) * GY + (iy + b)) * GZ + iz;
               c[a][b] = mix(node_val(comp, b0 % NODES), node_val(comp, (b0 + 1) % NODES),
                             wz);
            end
         v = mix(mix(c[0][0], c[0][1], wy), mix(c[1][0], c[1][1], wy), wx);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         return v[FIELD_W-1:0];
      endfunction

      // accepted request: loads update the store, queries queue a result
      function void note_request(bit cmd, int px, int py, int pz, int nbx, int nby,
                                 int nbz);
         int ix, iy, iz;
         longint wx, wy, wz;
         bit in_x, in_y, in_z;
         field_result_type r;
         if (cmd == CMD_LOAD) begin
            node_x[load_ptr] = nbx;
            node_y[load_ptr] = nby;
            node_z[load_ptr] = nbz;
            load_ptr = (load_ptr + 1) % NODES;
            return;
         end
         in_x = map_axis(px, origin[0], scale[0], GX, ix, wx);
         in_y = map_axis(py, origin[1], scale[1], GY, iy, wy);
         in_z = map_axis(pz, origin[2], scale[2], GZ, iz, wz);
         r = '0;
         if (in_x && in_y && in_z) begin
            r.bx = interp(0, ix, iy, iz, wx, wy, wz);
            r.by = interp(1, ix, iy, iz, wx, wy, wz);
            r.bz = interp(2, ix, iy, iz, wx, wy, wz);
            r.inside_res = 1'b1;
         end
         expected_fields.push_back(r);
      endfunction

      function void check_result(field_result_type got);
         field_result_type exp_r;
         if (expected_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: b=%0d %0d %0d inside_res=%0b",
                        got.bx, got.by, got.bz, got.inside_res);
            return;
         end
         exp_r = expected_fields.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"field mismatch: expected b=%0d %0d %0d inside_res=%0b, ",
                         "got b=%0d %0d %0d inside_res=%0b"},
                        exp_r.bx, exp_r.by, exp_r.bz, exp_r.inside_res,
                        got.bx, got.by, got.bz, got.inside_res);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = 1'b0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic signed [23:0] req_node_bx = '0;
   logic signed [23:0] req_node_by = '0;
   logic signed [23:0] req_node_bz = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_b_x;
   logic signed [23:0] rsp_b_y;
   logic signed [23:0] rsp_b_z;
   logic               rsp_inside_res;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   field_map_scoreboard field_sb;
   int                  cycle_count = 0;
   bit                  calm;

   trilinear_field_map_lookup #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) dut (.*);

   always #5 clock = ~clock;

   // recurring stretches without any idling on either side
   assign calm = (cycle_count % 1000) >= 800;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 14);
      end
   end

   // monitor both channels on pre-edge values
   always @(posedge clock) begin
      if (!reset && field_sb != null) begin
         if (req_valid && !req_stall)
            field_sb.note_request(req_cmd, req_pos_x, req_pos_y, req_pos_z,
                                  req_node_bx, req_node_by, req_node_bz);
         if (rsp_valid && !rsp_stall)
            field_sb.check_result({rsp_b_x, rsp_b_y, rsp_b_z, rsp_inside_res});
      end
   end

   // one request, optionally preceded by an idle stretch with req_valid low
   task automatic send_request(bit cmd, int px, int py, int pz, int nbx, int nby,
                               int nbz);
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_node_bx <= nbx[23:0];
      req_node_by <= nby[23:0];
      req_node_bz <= nbz[23:0];
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic load_node(int nbx, int nby, int nbz);
      send_request(CMD_LOAD, $urandom(), $urandom(), $urandom(), nbx, nby, nbz);
   endtask

   task automatic query_point(int px, int py, int pz);
      send_request(CMD_QUERY, px, py, pz, $urandom(), $urandom(), $urandom());
   endtask

   task automatic write_reg(logic [4:0] addr, int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      field_sb.origin[0] = (addr == REG_ORIGIN_X) ? value : field_sb.origin[0];
      field_sb.origin[1] = (addr == REG_ORIGIN_Y) ? value : field_sb.origin[1];
      field_sb.origin[2] = (addr == REG_ORIGIN_Z) ? value : field_sb.origin[2];
      field_sb.scale[0] = (addr == REG_SCALE_X) ? value : field_sb.scale[0];
      field_sb.scale[1] = (addr == REG_SCALE_Y) ? value : field_sb.scale[1];
      field_sb.scale[2] = (addr == REG_SCALE_Z) ? value : field_sb.scale[2];
   endtask

   // wait for all queued results, then let trailing loads settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (field_sb.expected_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mapping(int ox, int oy, int oz, int sx, int sy, int sz);
      drain_block();
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_Z, oz);
      write_reg(REG_SCALE_X, sx);
      write_reg(REG_SCALE_Y, sy);
      write_reg(REG_SCALE_Z, sz);
   endtask

   // position aimed at the first span cells of an axis, with edges and points just off the grid favored
   function automatic int aim_axis(int ax, int n, int span);
      longint t, d;
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) t = 0;
      else if (sel == 1) t = longint'(span) * 65536 - 1;
      else if (sel == 2) t = longint'(n - 1) * 65536;
      else if (sel == 3) t = -1;
      else t = $urandom_range(0, span * 65536 - 1);
      if (field_sb.scale[ax] == 0) d = $urandom_range(0, 65535) - 32768;
      else d = (t <<< 28) / longint'(field_sb.scale[ax]);
      return int'(longint'(field_sb.origin[ax]) + d);
   endfunction

   // position one cell below the grid start of an axis
   function automatic int below_axis(int ax);
      longint d;
      if (field_sb.scale[ax] == 0) d = 0;
      else d = (longint'(-65536) <<< 28) / longint'(field_sb.scale[ax]);
      return int'(longint'(field_sb.origin[ax]) + d);
   endfunction

   task automatic random_mix(int count);
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 15) load_node($urandom(), $urandom(), $urandom());
         else if (sel < 25) query_point(below_axis(0), $urandom(), $urandom());
         else query_point(aim_axis(0, GX, 1), aim_axis(1, GY, 1), aim_axis(2, GZ, GZ - 1));
      end
   endtask

   initial begin
      field_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // off-grid queries before any node exists
      query_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      query_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      query_point(-1, 0, 0);
      query_point(0, 0, (GZ - 1) * 65536);

      // fill the queried part of the grid, extremes at the start
      load_node(32'h7F_FFFF, 32'h80_0000, 0);
      load_node(32'h80_0000, 32'h7F_FFFF, -1);
      load_node(-1, 0, 32'h7F_FFFF);
      load_node(0, -1, 32'h80_0000);
      for (int k = 4; k < LOADED; k++) load_node($urandom(), $urandom(), $urandom());

      // grid corners and the strict upper bound at default mapping
      query_point(0, 0, 0);
      query_point(65535, 65535, (GZ - 1) * 65536 - 1);
      query_point((GX - 1) * 65536, 0, 0);
      query_point(0, (GY - 1) * 65536, 0);
      query_point(32768, 32768, 32768);
      query_point(0, 0, 1);
      // a load past the queried region leaves it unchanged
      load_node(12345, -54321, 777);
      query_point(0, 0, 0);
      random_mix(45);

      // inverted y, mixed step sizes
      set_mapping($urandom(), $urandom(), $urandom(), SCALE_ONE / 2, -SCALE_ONE,
                  SCALE_ONE * 2);
      random_mix(45);

      // zero scale on z, extreme origins
      set_mapping(32'sh8000_0000, 32'sh7FFF_FFFF, $urandom(), SCALE_ONE, -SCALE_ONE, 0);
      query_point(32'sh8000_0000, 32'sh7FFF_FFFF, $urandom());
      random_mix(45);

      // extreme scales
      set_mapping($urandom(), $urandom(), $urandom(), 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh7FFF_FFFF);
      random_mix(45);

      // random scales of either sign
      set_mapping($urandom(), $urandom(), $urandom(),
                  $urandom_range(1 << 20, 1 << 30), -$urandom_range(1 << 20, 1 << 30),
                  $urandom_range(1 << 20, 1 << 30));
      random_mix(45);

      drain_block();
      if (field_sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
